@@ src/fbblur_pkg.sv @@
`default_nettype none

package fbblur_pkg;

   // Frame geometry
   localparam int unsigned WIDTH  = 16;
   localparam int unsigned HEIGHT = 16;
   localparam int unsigned NPIX   = WIDTH * HEIGHT;

   // Counter and address widths
   localparam int unsigned XW = (WIDTH  > 1) ? $clog2(WIDTH)  : 1;
   localparam int unsigned YW = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
   localparam int unsigned AW = (NPIX   > 1) ? $clog2(NPIX)   : 1;

   localparam logic [7:0] CH_MAX = 8'd255;

   typedef logic [AW-1:0] addr_type;
   typedef logic [XW-1:0] xpos_type;
   typedef logic [YW-1:0] ypos_type;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FILL  = 2'd2,
      CMD_BLUR  = 2'd3
   } cmd_type;

   // Request word
   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] col_x;
      logic [3:0] row_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] amount;
   } req_type;

   // Response word
   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   // One stored pixel
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Colour channels only
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   localparam pixel_type PIXEL_RESET = '{alpha: CH_MAX, red: 8'd0, green: 8'd0, blue: 8'd0};

   // Position lies inside the frame
   function automatic logic inside_frame(logic [3:0] x, logic [3:0] y);
      return (int'(x) < int'(WIDTH)) && (int'(y) < int'(HEIGHT));
   endfunction

   // Linear pixel address, row major
   function automatic addr_type pix_addr(logic [3:0] x, logic [3:0] y);
      return addr_type'(AW'(y) * AW'(WIDTH) + AW'(x));
   endfunction

   // (v*s)>>8
   function automatic logic [7:0] scale_ch(logic [7:0] v, logic [7:0] s);
      logic [15:0] prod;
      prod = 16'(v) * 16'(s);
      return prod[15:8];
   endfunction

   // Add with clamp at 255
   function automatic logic [7:0] sat_ch(logic [7:0] a, logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[8] ? CH_MAX : sum[7:0];
   endfunction

   function automatic rgb_type scale3(pixel_type p, logic [7:0] s);
      rgb_type r;
      r.red   = scale_ch(p.red,   s);
      r.green = scale_ch(p.green, s);
      r.blue  = scale_ch(p.blue,  s);
      return r;
   endfunction

   function automatic rgb_type sat3(rgb_type a, rgb_type b);
      rgb_type r;
      r.red   = sat_ch(a.red,   b.red);
      r.green = sat_ch(a.green, b.green);
      r.blue  = sat_ch(a.blue,  b.blue);
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/framebuffer_separable_blur_unit.sv @@
`default_nettype none
// Pixel frame store with an in-place three-tap separable blur.
// Request channel (req_valid / req_stall / req_data) carries one command word:
// write pixel, read pixel, fill the frame, or blur the frame. Every command
// returns exactly one response word on rsp_valid / rsp_stall / rsp_data; it
// holds the read pixel for a read and zero for everything else.
// The unit takes one command at a time; req_stall is high while it works.
// Work per command, from acceptance to the response being loaded:
//    write, read : one store access, then the response is loaded
//    fill        : one pixel written per cycle across the whole frame
//    blur        : rows first, then columns; two pixel scalers (keep and
//                  seep weights) and two saturating adders handle every
//                  pixel of both passes, a scale step then an accumulate
//                  step per pixel, plus a fetch and a flush per line.
// The response sits in an output register: a stalled receiver only delays
// the end of the command, and the next command is taken once it is loaded.
// Reset (synchronous, active high) starts a clearing sweep that writes
// alpha 255, colour zero to every pixel; no command is taken and no
// response is produced during it.
module framebuffer_separable_blur_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire fbblur_pkg::req_type req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      fbblur_pkg::rsp_type rsp_data
);
   import fbblur_pkg::*;

   typedef enum logic [2:0] {
      S_FILL,
      S_IDLE,
      S_LINE,
      S_MUL,
      S_ACC,
      S_FLUSH,
      S_DONE
   } state_type;

   // Frame store
   pixel_type mem [NPIX];
   pixel_type mem_q_ff;
   logic      mem_wr_en;
   addr_type  mem_wr_addr;
   pixel_type mem_wr_data;
   logic      mem_rd_en;
   addr_type  mem_rd_addr;

   // Sequencer and datapath registers
   state_type  state_ff,     state_in;
   addr_type   sweep_ff,     sweep_in;
   pixel_type  fill_ff,      fill_in;
   logic       fill_resp_ff, fill_resp_in;
   logic       out_read_ff,  out_read_in;
   logic [7:0] keep_ff,      keep_in;
   logic [7:0] seep_ff,      seep_in;
   logic       pass_ff,      pass_in;
   xpos_type   x_ff,         x_in;
   ypos_type   y_ff,         y_in;
   addr_type   cur_addr_ff,  cur_addr_in;
   addr_type   prev_addr_ff, prev_addr_in;
   logic       first_ff,     first_in;
   rgb_type    kv_ff,        kv_in;
   rgb_type    part_ff,      part_in;
   rgb_type    carry_ff,     carry_in;
   pixel_type  acc_ff,       acc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff,  rsp_data_in;

   logic      req_acc;
   logic      req_inside;
   addr_type  req_addr;
   pixel_type req_pixel;
   logic      pos_last;
   logic      line_last;
   addr_type  stride;
   addr_type  next_addr;
   rgb_type   acc_new;
   rgb_type   prev_out;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_acc    = req_valid && !req_stall;
   assign req_inside = inside_frame(req_data.col_x, req_data.row_y);
   assign req_addr   = pix_addr(req_data.col_x, req_data.row_y);
   assign req_pixel  = '{alpha: req_data.alpha, red: req_data.red,
                         green: req_data.green, blue: req_data.blue};

   // Line walk: rows first (pass 0), then columns (pass 1)
   assign pos_last  = pass_ff ? (y_ff == YW'(HEIGHT - 1)) : (x_ff == XW'(WIDTH - 1));
   assign line_last = pass_ff ? (x_ff == XW'(WIDTH - 1))  : (y_ff == YW'(HEIGHT - 1));
   assign stride    = pass_ff ? AW'(WIDTH) : AW'(1);
   assign next_addr = cur_addr_ff + stride;

   // Two saturating adders: current pixel takes its left part, previous its right part
   assign acc_new  = sat3(kv_ff, carry_ff);
   assign prev_out = sat3(rgb_type'({acc_ff.red, acc_ff.green, acc_ff.blue}), part_ff);

   // Next-state and store control
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      fill_in      = fill_ff;
      fill_resp_in = fill_resp_ff;
      out_read_in  = out_read_ff;
      keep_in      = keep_ff;
      seep_in      = seep_ff;
      pass_in      = pass_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cur_addr_in  = cur_addr_ff;
      prev_addr_in = prev_addr_ff;
      first_in     = first_ff;
      kv_in        = kv_ff;
      part_in      = part_ff;
      carry_in     = carry_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = prev_addr_ff;
      mem_wr_data  = acc_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = cur_addr_ff;

      case (state_ff)
         S_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = fill_ff;
            sweep_in    = sweep_ff + AW'(1);
            if (sweep_ff == AW'(NPIX - 1)) begin
               state_in = fill_resp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               out_read_in = 1'b0;
               case (req_data.cmd)
                  CMD_WRITE: begin
                     mem_wr_en   = req_inside;
                     mem_wr_addr = req_addr;
                     mem_wr_data = req_pixel;
                     state_in    = S_DONE;
                  end
                  CMD_READ: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = req_addr;
                     out_read_in = req_inside;
                     state_in    = S_DONE;
                  end
                  CMD_FILL: begin
                     fill_in      = req_pixel;
                     sweep_in     = '0;
                     fill_resp_in = 1'b1;
                     state_in     = S_FILL;
                  end
                  CMD_BLUR: begin
                     keep_in     = CH_MAX - req_data.amount;
                     seep_in     = {1'b0, req_data.amount[7:1]};
                     pass_in     = 1'b0;
                     x_in        = '0;
                     y_in        = '0;
                     cur_addr_in = '0;
                     state_in    = S_LINE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // Start of a line: fetch its first pixel, no left neighbour
         S_LINE: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cur_addr_ff;
            carry_in    = '0;
            first_in    = 1'b1;
            state_in    = S_MUL;
         end
         // Keep and seep scalers on the fetched pixel
         S_MUL: begin
            kv_in    = scale3(mem_q_ff, keep_ff);
            part_in  = scale3(mem_q_ff, seep_ff);
            state_in = S_ACC;
         end
         // Finish previous pixel, accumulate current, fetch next
         S_ACC: begin
            if (!first_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = prev_addr_ff;
               mem_wr_data = '{alpha: acc_ff.alpha, red: prev_out.red,
                               green: prev_out.green, blue: prev_out.blue};
            end
            acc_in       = '{alpha: mem_q_ff.alpha, red: acc_new.red,
                             green: acc_new.green, blue: acc_new.blue};
            carry_in     = part_ff;
            prev_addr_in = cur_addr_ff;
            first_in     = 1'b0;
            if (pos_last) begin
               state_in = S_FLUSH;
            end else begin
               if (pass_ff) begin
                  y_in = y_ff + YW'(1);
               end else begin
                  x_in = x_ff + XW'(1);
               end
               cur_addr_in = next_addr;
               mem_rd_en   = 1'b1;
               mem_rd_addr = next_addr;
               state_in    = S_MUL;
            end
         end
         // Last pixel of a line has no right neighbour
         S_FLUSH: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = prev_addr_ff;
            mem_wr_data = acc_ff;
            if (line_last) begin
               if (pass_ff) begin
                  state_in = S_DONE;
               end else begin
                  pass_in     = 1'b1;
                  x_in        = '0;
                  y_in        = '0;
                  cur_addr_in = '0;
                  state_in    = S_LINE;
               end
            end else begin
               if (pass_ff) begin
                  x_in        = x_ff + XW'(1);
                  y_in        = '0;
                  cur_addr_in = AW'(x_ff) + AW'(1);
               end else begin
                  y_in        = y_ff + YW'(1);
                  x_in        = '0;
                  cur_addr_in = prev_addr_ff + AW'(1);
               end
               state_in = S_LINE;
            end
         end
         // Load the response word once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (out_read_ff) begin
                  rsp_data_in = '{out_red: mem_q_ff.red, out_green: mem_q_ff.green,
                                  out_blue: mem_q_ff.blue, out_alpha: mem_q_ff.alpha};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mem_q_ff <= mem[mem_rd_addr];
      end
   end

   // Sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         sweep_ff     <= '0;
         fill_ff      <= PIXEL_RESET;
         fill_resp_ff <= 1'b0;
         out_read_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fill_ff      <= fill_in;
         fill_resp_ff <= fill_resp_in;
         out_read_ff  <= out_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      keep_ff      <= keep_in;
      seep_ff      <= seep_in;
      pass_ff      <= pass_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      cur_addr_ff  <= cur_addr_in;
      prev_addr_ff <= prev_addr_in;
      first_ff     <= first_in;
      kv_ff        <= kv_in;
      part_ff      <= part_in;
      carry_ff     <= carry_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A pixel is never read in the cycle it is rewritten
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("store read and write hit the same pixel");

   // A response only appears from the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response loaded outside completion");

   // The first pixel of a line has no left pixel to write back
   a_first_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && first_ff) |-> !mem_wr_en)
      else $error("write-back on first pixel of a line");

   // End of a line leads to the next line or to completion
   a_flush_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |=> (state_ff == S_LINE || state_ff == S_DONE))
      else $error("bad step after line end");
`endif

endmodule

`default_nettype wire

@@ tb/frame_blur_monitor.sv @@
`default_nettype none

// Watches both channels of the blur unit, keeps its own copy of the frame,
// predicts the response to every accepted command and checks the responses.
module frame_blur_monitor (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire fbblur_pkg::req_type req_data,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire fbblur_pkg::rsp_type rsp_data,
   output int                       mismatch_count,
   output int                       owed_count
);
   import fbblur_pkg::*;

   localparam pixel_type OUTSIDE_PX = '0;

   pixel_type frame_img [NPIX];
   rsp_type   owed_responses [$];

   // (v*s)>>8
   function automatic logic [7:0] shrink(logic [7:0] v, logic [7:0] s);
      logic [15:0] prod;
      prod = 16'(v) * 16'(s);
      return prod[15:8];
   endfunction

   // add, clamped at full scale
   function automatic logic [7:0] clamp_add(logic [7:0] a, logic [7:0] b);
      logic [8:0] sum;
      sum = 9'(a) + 9'(b);
      return (sum > 9'd255) ? 8'd255 : sum[7:0];
   endfunction

   // one pixel of one pass: left term first, then right; alpha untouched
   function automatic pixel_type three_tap(pixel_type mid, pixel_type lft, pixel_type rgt,
                                           logic [7:0] keep, logic [7:0] seep);
      pixel_type p;
      p.alpha = mid.alpha;
      p.red   = clamp_add(clamp_add(shrink(mid.red, keep), shrink(lft.red, seep)),
                          shrink(rgt.red, seep));
      p.green = clamp_add(clamp_add(shrink(mid.green, keep), shrink(lft.green, seep)),
                          shrink(rgt.green, seep));
      p.blue  = clamp_add(clamp_add(shrink(mid.blue, keep), shrink(lft.blue, seep)),
                          shrink(rgt.blue, seep));
      return p;
   endfunction

   // rows first, then columns; each pass reads the frame as it was before it
   function automatic void blur_frame(logic [7:0] amount);
      pixel_type  snap [NPIX];
      logic [7:0] keep;
      logic [7:0] seep;
      int         i;
      keep = 8'd255 - amount;
      seep = amount >> 1;
      snap = frame_img;
      for (int y = 0; y < HEIGHT; y++) begin
         for (int x = 0; x < WIDTH; x++) begin
            i = y * WIDTH + x;
            frame_img[i] = three_tap(snap[i],
                                     (x > 0) ? snap[i-1] : OUTSIDE_PX,
                                     (x < WIDTH - 1) ? snap[i+1] : OUTSIDE_PX,
                                     keep, seep);
         end
      end
      snap = frame_img;
      for (int x = 0; x < WIDTH; x++) begin
         for (int y = 0; y < HEIGHT; y++) begin
            i = y * WIDTH + x;
            frame_img[i] = three_tap(snap[i],
                                     (y > 0) ? snap[i-WIDTH] : OUTSIDE_PX,
                                     (y < HEIGHT - 1) ? snap[i+WIDTH] : OUTSIDE_PX,
                                     keep, seep);
         end
      end
   endfunction

   // apply one command word to the frame copy and return the word it answers with
   function automatic rsp_type run_command(req_type w);
      rsp_type res;
      logic    on_frame;
      int      idx;
      res      = '0;
      on_frame = (int'(w.col_x) < WIDTH) && (int'(w.row_y) < HEIGHT);
      idx      = int'(w.row_y) * WIDTH + int'(w.col_x);
      case (w.cmd)
         CMD_WRITE: begin
            if (on_frame) begin
               frame_img[idx] = '{alpha: w.alpha, red: w.red, green: w.green, blue: w.blue};
            end
         end
         CMD_READ: begin
            if (on_frame) begin
               res.out_red   = frame_img[idx].red;
               res.out_green = frame_img[idx].green;
               res.out_blue  = frame_img[idx].blue;
               res.out_alpha = frame_img[idx].alpha;
            end
         end
         CMD_FILL: begin
            foreach (frame_img[k]) begin
               frame_img[k] = '{alpha: w.alpha, red: w.red, green: w.green, blue: w.blue};
            end
         end
         CMD_BLUR: begin
            blur_frame(w.amount);
         end
         default: begin
            res = '0;
         end
      endcase
      return res;
   endfunction

   task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      end
   endtask

   // response check first, then the new expectation: the response is always older
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         foreach (frame_img[k]) begin
            frame_img[k] = '{alpha: 8'd255, red: 8'd0, green: 8'd0, blue: 8'd0};
         end
         owed_responses.delete();
         owed_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_responses.size() == 0) begin
               mismatch_count++;
               $error("response word %h with nothing outstanding", rsp_data);
            end else begin
               want = owed_responses.pop_front();
               check_field("out_red",   want.out_red,   rsp_data.out_red);
               check_field("out_green", want.out_green, rsp_data.out_green);
               check_field("out_blue",  want.out_blue,  rsp_data.out_blue);
               check_field("out_alpha", want.out_alpha, rsp_data.out_alpha);
            end
         end
         if (req_valid && !req_stall) begin
            owed_responses.push_back(run_command(req_data));
         end
         owed_count <= owed_responses.size();
      end
   end

endmodule

`default_nettype wire

@@ tb/framebuffer_separable_blur_unit_test.sv @@
`default_nettype none

module framebuffer_separable_blur_unit_test;
   import fbblur_pkg::*;

   localparam int DIRECTED_WORDS = 25;
   localparam int RANDOM_WORDS   = 1000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      fail_total;
   int      owed_total;
   int      words_sent = 0;
   int      hold_left  = 0;
   logic    quiet      = 1'b0;
   logic    drained    = 1'b0;

   framebuffer_separable_blur_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   frame_blur_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (fail_total),
      .owed_count     (owed_total)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(100_000_000);
      $display("FAIL");
      $finish;
   end

   // receiver back-pressure: mostly free, some short stalls, a few long ones
   always @(posedge clock) begin : rsp_backpressure
      int roll;
      roll = $urandom_range(0, 99);
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (quiet || roll < 70) begin
         rsp_stall <= 1'b0;
      end else if (roll < 95) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(10, 40);
      end
   end

   function automatic req_type compose(cmd_type c, logic [3:0] x, logic [3:0] y,
                                       logic [31:0] argb, logic [7:0] amt);
      req_type w;
      w.cmd    = c;
      w.col_x  = x;
      w.row_y  = y;
      w.alpha  = argb[31:24];
      w.red    = argb[23:16];
      w.green  = argb[15:8];
      w.blue   = argb[7:0];
      w.amount = amt;
      return w;
   endfunction

   // a position near c, kept on the frame
   function automatic logic [3:0] jitter(logic [3:0] c);
      int p;
      p = int'(c) + int'($urandom_range(0, 4)) - 2;
      if (p < 0) p = 0;
      if (p > 15) p = 15;
      return 4'(p);
   endfunction

   function automatic logic [7:0] blur_strength();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic cmd_type pick_cmd();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return CMD_READ;
      if (roll < 80) return CMD_WRITE;
      if (roll < 88) return CMD_FILL;
      return CMD_BLUR;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // hold the word until taken, then maybe idle a while
   task automatic push_word(req_type w);
      int gap;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every outstanding response
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_total != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [3:0] cx;
      logic [3:0] cy;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, corners, extreme colours and blur strengths
      push_word(compose(CMD_READ,  4'd0,  4'd0,  $urandom, 8'($urandom)));
      push_word(compose(CMD_READ,  4'd15, 4'd15, $urandom, 8'($urandom)));
      push_word(compose(CMD_WRITE, 4'd0,  4'd0,  32'hFFFF_FFFF, 8'hFF));
      push_word(compose(CMD_WRITE, 4'd15, 4'd15, 32'h0000_0000, 8'h00));
      push_word(compose(CMD_WRITE, 4'd15, 4'd0,  32'h5AA5_C33C, 8'($urandom)));
      push_word(compose(CMD_WRITE, 4'd0,  4'd15, 32'hA55A_3CC3, 8'($urandom)));
      push_word(compose(CMD_READ,  4'd0,  4'd0,  $urandom, 8'($urandom)));
      push_word(compose(CMD_READ,  4'd15, 4'd15, $urandom, 8'($urandom)));
      push_word(compose(CMD_READ,  4'd15, 4'd0,  $urandom, 8'($urandom)));
      push_word(compose(CMD_READ,  4'd0,  4'd15, $urandom, 8'($urandom)));
      // zero strength only shrinks each channel
      push_word(compose(CMD_BLUR,  4'($urandom), 4'($urandom), $urandom, 8'd0));
      push_word(compose(CMD_READ,  4'd0,  4'd0,  $urandom, 8'($urandom)));
      push_word(compose(CMD_BLUR,  4'($urandom), 4'($urandom), $urandom, 8'd255));
      push_word(compose(CMD_READ,  4'd15, 4'd0,  $urandom, 8'($urandom)));
      push_word(compose(CMD_FILL,  4'($urandom), 4'($urandom), 32'h80FF_FFFF, 8'($urandom)));
      push_word(compose(CMD_BLUR,  4'($urandom), 4'($urandom), $urandom, 8'd255));
      push_word(compose(CMD_READ,  4'd7,  4'd7,  $urandom, 8'($urandom)));
      push_word(compose(CMD_READ,  4'd0,  4'd15, $urandom, 8'($urandom)));
      push_word(compose(CMD_FILL,  4'($urandom), 4'($urandom), 32'h0000_0000, 8'hFF));
      push_word(compose(CMD_READ,  4'd3,  4'd9,  $urandom, 8'($urandom)));
      push_word(compose(CMD_WRITE, 4'd8,  4'd8,  32'hFFFF_FFFF, 8'($urandom)));
      push_word(compose(CMD_BLUR,  4'($urandom), 4'($urandom), $urandom, 8'd1));
      push_word(compose(CMD_BLUR,  4'($urandom), 4'($urandom), $urandom, 8'd128));
      push_word(compose(CMD_READ,  4'd8,  4'd8,  $urandom, 8'($urandom)));
      push_word(compose(CMD_READ,  4'd7,  4'd8,  $urandom, 8'($urandom)));

      // random: mostly paint-blur-inspect scenes, some loose noise
      while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
         quiet <= ($urandom_range(0, 4) == 0);
         if (!drained && words_sent >= DIRECTED_WORDS + RANDOM_WORDS / 2) begin
            settle();
            drained = 1'b1;
         end
         if ($urandom_range(0, 9) < 7) begin
            cx = 4'($urandom);
            cy = 4'($urandom);
            if ($urandom_range(0, 3) == 0) begin
               cx = $urandom_range(0, 1) ? 4'd15 : 4'd0;
               cy = $urandom_range(0, 1) ? 4'd15 : 4'd0;
            end
            if ($urandom_range(0, 3) == 0) begin
               push_word(compose(CMD_FILL, 4'($urandom), 4'($urandom), $urandom,
                                 8'($urandom)));
            end
            repeat ($urandom_range(1, 8)) begin
               push_word(compose(CMD_WRITE, jitter(cx), jitter(cy), $urandom, 8'($urandom)));
            end
            repeat ($urandom_range(1, 2)) begin
               push_word(compose(CMD_BLUR, 4'($urandom), 4'($urandom), $urandom,
                                 blur_strength()));
            end
            repeat ($urandom_range(2, 8)) begin
               push_word(compose(CMD_READ, jitter(cx), jitter(cy), $urandom, 8'($urandom)));
            end
         end else begin
            repeat ($urandom_range(1, 10)) begin
               push_word(compose(pick_cmd(), 4'($urandom), 4'($urandom), $urandom,
                                 8'($urandom)));
            end
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (fail_total == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
